// ===== rtl/lppd_pkg.sv =====
// Shared types and constants for the length-prefixed packet deframer.
// No dependencies; used by every module in rtl/.
`default_nettype none

package lppd_pkg;

    localparam logic       CMD_DATA  = 1'b0;
    localparam logic       CMD_CLOSE = 1'b1;

    localparam logic [1:0] KIND_HEADER     = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD    = 2'd1;
    localparam logic [1:0] KIND_BAD_LENGTH = 2'd2;
    localparam logic [1:0] KIND_CLOSED     = 2'd3;

    localparam logic [7:0] HEADER_BYTES    = 8'd3;
    localparam logic [7:0] MIN_LENGTH_RST  = 8'd3;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } lppd_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  packet_type;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
    } lppd_out_t;

endpackage

`default_nettype wire

// ===== rtl/length_prefixed_packet_deframer.sv =====
// Top level of the length-prefixed packet deframer: input register, framing core,
// result register and the min_length register. Depends on lppd_pkg and lppd_* modules.
//
//   channel   handshake               word
//   in        in_valid / in_ready     in_data  (command, rx_byte)
//   out       out_valid / out_ready   out_data (kind, packet_type, payload_length,
//                                               payload_byte, last)
//   cfg       cfg_we                  cfg_wdata (min_length)
//
// One word a cycle unless the output stalls; results leave via the result register.
// Length bytes, unless the length is too short, and dropped words give no result.
// rst_n clears framing state, halt flag and min_length (to 3).
// A stalled output holds one result; input keeps flowing until the input register fills.
`default_nettype none

module length_prefixed_packet_deframer
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lppd_pkg::lppd_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lppd_pkg::lppd_out_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_wdata
);

    logic                item_valid;
    lppd_pkg::lppd_in_t  item;
    logic                fire;
    logic                space;
    logic                res_valid;
    lppd_pkg::lppd_out_t res;
    logic [7:0]          min_length_reg;

    assign fire = item_valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= lppd_pkg::MIN_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            min_length_reg <= cfg_wdata;
        end
    end

    lppd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (fire)
    );

    lppd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item),
        .min_length (min_length_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    lppd_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .space      (space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/lppd_in_stage.sv =====
// Input register stage: holds one received word until the framing core takes it.
// Depends on lppd_pkg.
`default_nettype none

module lppd_in_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lppd_pkg::lppd_in_t in_data,
    output logic                   item_valid,
    output lppd_pkg::lppd_in_t     item,
    input  wire logic              item_take
);

    logic               valid_reg;
    logic               valid_next;
    lppd_pkg::lppd_in_t data_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lppd_core.sv =====
// Framing state machine: length bytes, type byte, payload count, error halt.
// Depends on lppd_pkg.
`default_nettype none

module lppd_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire lppd_pkg::lppd_in_t item,
    input  wire logic [7:0]         min_length,
    output logic                    res_valid,
    output lppd_pkg::lppd_out_t     res
);

    typedef enum logic [1:0] {
        PH_LEN_LO,
        PH_LEN_HI,
        PH_TYPE,
        PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] total_reg;
    logic [15:0] total_next;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic [7:0]  type_reg;
    logic [7:0]  type_next;
    logic        halted_reg;
    logic        halted_next;

    logic [7:0]  minimum;
    logic [15:0] full_length;
    logic [15:0] plen;
    logic [15:0] rem_dec;

    assign minimum     = (min_length < lppd_pkg::HEADER_BYTES) ?
                         lppd_pkg::HEADER_BYTES : min_length;
    assign full_length = {item.rx_byte, total_reg[7:0]};
    assign plen        = total_reg - {8'd0, lppd_pkg::HEADER_BYTES};
    assign rem_dec     = (remaining_reg != 16'd0) ? remaining_reg - 16'd1 : remaining_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        total_next     = total_reg;
        remaining_next = remaining_reg;
        type_next      = type_reg;
        halted_next    = halted_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (fire && !halted_reg)
        begin
            if (item.command == lppd_pkg::CMD_CLOSE)
            begin
                halted_next = 1'b1;
                res_valid   = 1'b1;
                res.kind    = lppd_pkg::KIND_CLOSED;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEN_LO:
                    begin
                        total_next = {8'd0, item.rx_byte};
                        phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        total_next = full_length;
                        if (full_length < {8'd0, minimum})
                        begin
                            halted_next = 1'b1;
                            res_valid   = 1'b1;
                            res.kind    = lppd_pkg::KIND_BAD_LENGTH;
                        end
                        else
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_next          = item.rx_byte;
                        remaining_next     = plen;
                        phase_next         = (plen == 16'd0) ? PH_LEN_LO : PH_PAYLOAD;
                        res_valid          = 1'b1;
                        res.kind           = lppd_pkg::KIND_HEADER;
                        res.packet_type    = item.rx_byte;
                        res.payload_length = plen;
                        res.last           = (plen == 16'd0);
                    end
                    PH_PAYLOAD:
                    begin
                        remaining_next     = rem_dec;
                        if (rem_dec == 16'd0)
                        begin
                            phase_next = PH_LEN_LO;
                        end
                        res_valid          = 1'b1;
                        res.kind           = lppd_pkg::KIND_PAYLOAD;
                        res.packet_type    = type_reg;
                        res.payload_length = plen;
                        res.payload_byte   = item.rx_byte;
                        res.last           = (rem_dec == 16'd0);
                    end
                    default:
                    begin
                        phase_next = PH_LEN_LO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN_LO;
            total_reg     <= 16'd0;
            remaining_reg <= 16'd0;
            type_reg      <= 8'd0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            total_reg     <= total_next;
            remaining_reg <= remaining_next;
            type_reg      <= type_next;
            halted_reg    <= halted_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !res_valid)
        else $error("result produced while halted");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.kind == lppd_pkg::KIND_BAD_LENGTH ||
                       res.kind == lppd_pkg::KIND_CLOSED)) |=> halted_reg)
        else $error("error result did not halt");

    a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == lppd_pkg::KIND_HEADER) |->
            (res.last == (res.payload_length == 16'd0)))
        else $error("header last flag disagrees with payload length");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (remaining_reg != 16'd0))
        else $error("payload phase with nothing remaining");
`endif

endmodule

`default_nettype wire

// ===== rtl/lppd_out_stage.sv =====
// Result register: holds one result word until the consumer takes it.
// Depends on lppd_pkg.
`default_nettype none

module lppd_out_stage
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                res_valid,
    input  wire lppd_pkg::lppd_out_t res,
    output logic                     space,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lppd_pkg::lppd_out_t      out_data
);

    logic                valid_reg;
    logic                valid_next;
    lppd_pkg::lppd_out_t data_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== verif/length_prefixed_packet_deframer_tb.sv =====
`timescale 1ns / 1ps
// Testbench for length_prefixed_packet_deframer: framed byte streams in, checked header,
// payload and error words out, via a scoreboard class that tracks framing state. Depends on lppd_pkg.

module length_prefixed_packet_deframer_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int WORD_TARGET = 1750;
    localparam int HOLD_CYCLES = 120;

    typedef enum logic [1:0]
    {
        AWAIT_LEN_LO,
        AWAIT_LEN_HI,
        AWAIT_TYPE,
        IN_PAYLOAD
    } frame_stage_t;

    class packet_tracker_t;
        logic [7:0]          min_length;
        frame_stage_t        stage;
        logic [15:0]         total_length;
        logic [15:0]         remaining;
        logic [7:0]          cur_type;
        bit                  halted;
        lppd_pkg::lppd_out_t expected_results[$];
        int                  errors;

        function new();
            min_length   = lppd_pkg::MIN_LENGTH_RST;
            stage        = AWAIT_LEN_LO;
            total_length = '0;
            remaining    = '0;
            cur_type     = '0;
            halted       = 1'b0;
            errors       = 0;
        endfunction

        function void add_expected(lppd_pkg::lppd_out_t r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void note_word(lppd_pkg::lppd_in_t w);
            lppd_pkg::lppd_out_t r;
            logic [15:0]         floor_len;
            logic [15:0]         plen;
            if (halted)
                return;
            r = '0;
            if (w.command == lppd_pkg::CMD_CLOSE)
            begin
                halted = 1'b1;
                r.kind = lppd_pkg::KIND_CLOSED;
                add_expected(r);
                return;
            end
            case (stage)
                AWAIT_LEN_LO:
                begin
                    total_length = {8'h00, w.rx_byte};
                    stage        = AWAIT_LEN_HI;
                end
                AWAIT_LEN_HI:
                begin
                    total_length[15:8] = w.rx_byte;
                    floor_len = (min_length < lppd_pkg::HEADER_BYTES) ?
                                {8'h00, lppd_pkg::HEADER_BYTES} : {8'h00, min_length};
                    if (total_length < floor_len)
                    begin
                        halted = 1'b1;
                        r.kind = lppd_pkg::KIND_BAD_LENGTH;
                        add_expected(r);
                    end
                    else
                        stage = AWAIT_TYPE;
                end
                AWAIT_TYPE:
                begin
                    cur_type         = w.rx_byte;
                    plen             = total_length - {8'h00, lppd_pkg::HEADER_BYTES};
                    remaining        = plen;
                    stage            = (plen == 16'd0) ? AWAIT_LEN_LO : IN_PAYLOAD;
                    r.kind           = lppd_pkg::KIND_HEADER;
                    r.packet_type    = cur_type;
                    r.payload_length = plen;
                    r.last           = (plen == 16'd0);
                    add_expected(r);
                end
                default:
                begin
                    plen = total_length - {8'h00, lppd_pkg::HEADER_BYTES};
                    if (remaining != 16'd0)
                        remaining = remaining - 16'd1;
                    if (remaining == 16'd0)
                        stage = AWAIT_LEN_LO;
                    r.kind           = lppd_pkg::KIND_PAYLOAD;
                    r.packet_type    = cur_type;
                    r.payload_length = plen;
                    r.payload_byte   = w.rx_byte;
                    r.last           = (remaining == 16'd0);
                    add_expected(r);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(lppd_pkg::lppd_out_t got);
            lppd_pkg::lppd_out_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected word expected none got %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", 16'(want.kind), 16'(got.kind));
            compare_field("packet_type", 16'(want.packet_type), 16'(got.packet_type));
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
            compare_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    lppd_pkg::lppd_in_t  in_data;
    logic                out_valid;
    logic                out_ready;
    lppd_pkg::lppd_out_t out_data;
    logic                cfg_we;
    logic [7:0]          cfg_wdata;

    packet_tracker_t tracker = new();
    int              cycles = 0;
    int              burst_left = 0;
    int              words_sent = 0;
    bit              stall_now = 1'b0;

    length_prefixed_packet_deframer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("length_prefixed_packet_deframer_tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_word(out_data);
    end

    // receiver: changing stall pattern, plus one long hold-off on request
    initial
    begin
        int mode;
        int span;
        mode      = 0;
        span      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_now)
            begin
                stall_now = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 200);
            end
            span--;
            case (mode)
                0:       out_ready = 1'b1;
                1:       out_ready = 1'($urandom_range(0, 1));
                2:       out_ready = ($urandom_range(0, 7) == 0);
                default: out_ready = ((cycles % 4) != 0);
            endcase
        end
    end

    task automatic send_word(input logic cmd, input logic [7:0] b);
        lppd_pkg::lppd_in_t w;
        int                 gap;
        w.command = cmd;
        w.rx_byte = b;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = w;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_word(w);
        words_sent++;
    endtask

    // fill < 0 gives random payload bytes
    task automatic send_packet(input int plen, input logic [7:0] ptype, input int fill);
        logic [15:0] total;
        total = 16'(plen + 3);
        send_word(lppd_pkg::CMD_DATA, total[7:0]);
        send_word(lppd_pkg::CMD_DATA, total[15:8]);
        send_word(lppd_pkg::CMD_DATA, ptype);
        for (int i = 0; i < plen; i++)
            send_word(lppd_pkg::CMD_DATA, (fill < 0) ? 8'($urandom) : fill[7:0]);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_min_length(input logic [7:0] v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        tracker.min_length = v;
    endtask

    function automatic int pick_payload(input logic [7:0] m);
        int base;
        int r;
        base = (m > 3) ? m - 3 : 0;
        r    = $urandom_range(0, 99);
        if (r < 55)
            return base + $urandom_range(0, 6);
        else if (r < 85)
            return base + $urandom_range(7, 30);
        else if (r < 97)
            return base + $urandom_range(31, 120);
        return base + $urandom_range(121, 300);
    endfunction

    initial
    begin
        logic [7:0]  m;
        logic [15:0] bad_total;
        logic [7:0]  floor_len;
        logic [7:0]  partial[0:7];
        int          phase_no;
        int          phase_end;
        int          n;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset value of min_length, empty payload and byte extremes
        send_packet(0, 8'hFF, 0);
        send_packet(1, 8'h00, 0);
        send_packet(2, 8'hA5, 8'hFF);
        send_packet(3, 8'h5A, -1);
        wait_idle();

        // top of the range: exact minimum, then a length with a non-zero high byte
        set_min_length(8'd255);
        send_packet(252, 8'($urandom), -1);
        send_packet(253, 8'($urandom), -1);
        wait_idle();

        set_min_length(8'd3);
        send_packet(0, 8'($urandom), -1);
        send_packet(0, 8'($urandom), -1);
        wait_idle();

        phase_no = 0;
        while (words_sent < WORD_TARGET)
        begin
            m = ($urandom_range(0, 3) == 0) ? 8'd3 : 8'($urandom_range(4, 60));
            set_min_length(m);
            if (phase_no == 2)
            begin
                stall_now  = 1'b1;
                burst_left = 300;
            end
            phase_end = words_sent + $urandom_range(100, 250);
            while (words_sent < phase_end)
                send_packet(pick_payload(m), 8'($urandom), -1);
            wait_idle();
            phase_no++;
        end

        // one halting error per run: bad length or remote close
        if ($urandom_range(0, 1) == 1)
        begin
            send_packet(pick_payload(tracker.min_length), 8'($urandom), -1);
            floor_len = (tracker.min_length < lppd_pkg::HEADER_BYTES) ?
                        lppd_pkg::HEADER_BYTES : tracker.min_length;
            if ($urandom_range(0, 2) == 0)
                bad_total = 16'($urandom_range(0, 2));
            else
                bad_total = 16'($urandom_range(0, floor_len - 1));
            send_word(lppd_pkg::CMD_DATA, bad_total[7:0]);
            send_word(lppd_pkg::CMD_DATA, bad_total[15:8]);
        end
        else
        begin
            n          = $urandom_range(0, 7);
            partial[0] = tracker.min_length + 8'd5;
            partial[1] = 8'h00;
            for (int i = 2; i < 8; i++)
                partial[i] = 8'($urandom);
            for (int i = 0; i < n; i++)
                send_word(lppd_pkg::CMD_DATA, partial[i]);
            send_word(lppd_pkg::CMD_CLOSE, 8'($urandom));
        end

        // halted: everything dropped, a close included
        send_word(lppd_pkg::CMD_CLOSE, 8'($urandom));
        repeat (12)
            send_word(1'($urandom_range(0, 1)), 8'($urandom));
        wait_idle();
        repeat (10) @(posedge clk);

        if (tracker.errors == 0)
            $display("length_prefixed_packet_deframer_tb: clean");
        else
            $display("length_prefixed_packet_deframer_tb: errors");
        $finish;
    end

endmodule

// ===== length_prefixed_packet_deframer.f =====
rtl/lppd_pkg.sv
rtl/lppd_in_stage.sv
rtl/lppd_core.sv
rtl/lppd_out_stage.sv
rtl/length_prefixed_packet_deframer.sv
verif/length_prefixed_packet_deframer_tb.sv
